@@ rtl/core/b32d_pkg.sv @@
// Shared types, constants and functions of the Base32 stream decoder.
package b32d_pkg;

	localparam int COUNT_BITS = 16;
	localparam int CAP_W      = 16;
	localparam int CMP_W      = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;
	localparam int BCNT_W     = 16;
	localparam int OUT_W      = 32;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [CAP_W-1:0] CAP_RESET = '1;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_SRCERR   = 2'd1;
	localparam status_t ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [4:0] sym;
		logic       is_pad;
		logic       is_bad;
		logic       last;
	} item_t;

	function automatic logic [2:0] pad_extra(input logic [2:0] mod5);
		logic [2:0] r;
		case (mod5)
			3'd1: r = 3'd5;
			3'd2: r = 3'd3;
			3'd3: r = 3'd2;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/b32d_front.sv @@
// Input side: accepts characters and classifies them into symbol, pad or invalid.
module b32d_front (
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] char_code
	input  logic                s_tlast,   // last_char
	input  logic                full,
	output logic                push,
	output b32d_pkg::item_t     item
);

	logic [4:0] sym;
	logic       is_sym;

	always_comb begin
		sym    = 5'd0;
		is_sym = 1'b1;
		if (s_tdata >= 8'h41 && s_tdata <= 8'h5A) begin
			sym = 5'(s_tdata - 8'h41);
		end else if (s_tdata >= 8'h61 && s_tdata <= 8'h7A) begin
			sym = 5'(s_tdata - 8'h61);
		end else if (s_tdata >= 8'h32 && s_tdata <= 8'h37) begin
			sym = 5'(s_tdata - 8'h32 + 8'd26);
		end else begin
			is_sym = 1'b0;
		end
	end

	assign s_tready    = !full;
	assign push        = s_tvalid && !full;
	assign item.sym    = sym;
	assign item.is_pad = (s_tdata == b32d_pkg::PAD_CHAR);
	assign item.is_bad = !is_sym && (s_tdata != b32d_pkg::PAD_CHAR);
	assign item.last   = s_tlast;

endmodule

@@ rtl/core/b32d_fifo.sv @@
// Short queue of classified characters between the front and back parts.
module b32d_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b32d_pkg::item_t     push_item,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output b32d_pkg::item_t     head
);

	b32d_pkg::item_t mem_q [b32d_pkg::FIFO_DEPTH];
	logic [b32d_pkg::FIFO_AW:0] wr_ptr_q;
	logic [b32d_pkg::FIFO_AW:0] rd_ptr_q;

	assign not_empty = (wr_ptr_q != rd_ptr_q);
	assign full      = (wr_ptr_q[b32d_pkg::FIFO_AW] != rd_ptr_q[b32d_pkg::FIFO_AW]) &&
	                   (wr_ptr_q[b32d_pkg::FIFO_AW-1:0] == rd_ptr_q[b32d_pkg::FIFO_AW-1:0]);
	assign head      = mem_q[rd_ptr_q[b32d_pkg::FIFO_AW-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q[b32d_pkg::FIFO_AW-1:0]] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/b32d_back.sv @@
// Decode side: updates the bit buffer, padding and error state and registers results.
module b32d_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [b32d_pkg::CAP_W-1:0]        cfg_wdata,
	input  logic                              item_valid,
	input  b32d_pkg::item_t                   item,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [b32d_pkg::OUT_W-1:0]        m_tdata,
	output logic                              m_tlast,
	output logic                              m_tuser
);

	logic [b32d_pkg::CAP_W-1:0]      cap_q;
	logic [6:0]                      buf_q;
	logic [2:0]                      bcnt_q;
	logic [b32d_pkg::COUNT_BITS-1:0] cnt_q;
	logic [2:0]                      mod5_q;
	logic                            pad_q;
	logic [2:0]                      pad_left_q;
	b32d_pkg::status_t               err_q;

	logic                            out_valid_q;
	logic                            out_byte_valid_q;
	logic [7:0]                      out_byte_q;
	logic                            out_done_q;
	b32d_pkg::status_t               out_status_q;
	logic [b32d_pkg::BCNT_W-1:0]     out_count_q;

	logic [6:0]                      buf_d;
	logic [2:0]                      bcnt_d;
	logic [b32d_pkg::COUNT_BITS-1:0] cnt_d;
	logic [2:0]                      mod5_d;
	logic                            pad_d;
	logic [2:0]                      pad_left_d;
	b32d_pkg::status_t               err_d;
	logic                            byte_valid;
	logic [7:0]                      byte_val;
	logic [11:0]                     acc;
	logic [3:0]                      n_sum;
	logic [3:0]                      n_left;
	logic [b32d_pkg::CMP_W-1:0]      cnt_ext;
	logic [b32d_pkg::CMP_W-1:0]      cnt_d_ext;
	logic [b32d_pkg::CMP_W-1:0]      cap_ext;

	assign pop     = item_valid && (!out_valid_q || m_tready);
	assign cnt_ext = b32d_pkg::CMP_W'(cnt_q);
	assign cap_ext = b32d_pkg::CMP_W'(cap_q);
	assign acc     = {buf_q, item.sym};
	assign n_sum   = {1'b0, bcnt_q} + 4'd5;
	assign n_left  = (n_sum >= 4'd8) ? (n_sum - 4'd8) : n_sum;
	assign cnt_d_ext = b32d_pkg::CMP_W'(cnt_d);

	always_comb begin
		buf_d      = buf_q;
		bcnt_d     = bcnt_q;
		cnt_d      = cnt_q;
		mod5_d     = mod5_q;
		pad_d      = pad_q;
		pad_left_d = pad_left_q;
		err_d      = err_q;
		byte_valid = 1'b0;
		byte_val   = 8'd0;
		if (err_q == b32d_pkg::ST_OK) begin
			if (pad_q) begin
				if (pad_left_q == 3'd0 || !item.is_pad) begin
					err_d = b32d_pkg::ST_SRCERR;
				end else begin
					pad_left_d = pad_left_q - 3'd1;
				end
			end else if (cnt_ext >= cap_ext) begin
				err_d = b32d_pkg::ST_OVERFLOW;
			end else if (item.is_pad) begin
				pad_d      = 1'b1;
				pad_left_d = b32d_pkg::pad_extra(mod5_q);
			end else if (item.is_bad) begin
				err_d = b32d_pkg::ST_SRCERR;
			end else begin
				if (n_sum >= 4'd8) begin
					byte_valid = 1'b1;
					byte_val   = 8'(acc >> n_left);
					cnt_d      = cnt_q + 1'b1;
					if (cnt_d == '0 || mod5_q == 3'd4) begin
						mod5_d = 3'd0;
					end else begin
						mod5_d = mod5_q + 3'd1;
					end
				end
				buf_d  = acc[6:0] & 7'((8'd1 << n_left) - 8'd1);
				bcnt_d = n_left[2:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= b32d_pkg::CAP_RESET;
			buf_q       <= '0;
			bcnt_q      <= '0;
			cnt_q       <= '0;
			mod5_q      <= '0;
			pad_q       <= 1'b0;
			pad_left_q  <= '0;
			err_q       <= b32d_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
				if (item.last) begin
					buf_q      <= '0;
					bcnt_q     <= '0;
					cnt_q      <= '0;
					mod5_q     <= '0;
					pad_q      <= 1'b0;
					pad_left_q <= '0;
					err_q      <= b32d_pkg::ST_OK;
				end else begin
					buf_q      <= buf_d;
					bcnt_q     <= bcnt_d;
					cnt_q      <= cnt_d;
					mod5_q     <= mod5_d;
					pad_q      <= pad_d;
					pad_left_q <= pad_left_d;
					err_q      <= err_d;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_valid_q <= byte_valid;
			out_byte_q       <= byte_val;
			out_done_q       <= item.last;
			out_status_q     <= item.last ? err_d : b32d_pkg::ST_OK;
			out_count_q      <= cnt_d_ext[b32d_pkg::BCNT_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_byte_valid_q;
	assign m_tlast  = out_done_q;
	assign m_tdata  = b32d_pkg::OUT_W'({out_count_q, out_status_q, out_byte_q});

endmodule

@@ rtl/core/base32_stream_decoder.sv @@
// Top level of the Base32 stream decoder.
// Usage:
//   s_* channel: one ASCII character per transaction in s_tdata, s_tlast marks
//   the last character of a message.
//   m_* channel: one result per character. m_tuser flags a decoded byte in
//   m_tdata[7:0]; m_tlast marks the result of the last character, where
//   m_tdata[9:8] carries the status (0 ok, 1 source error, 2 overflow).
//   m_tdata[25:10] always carries the byte count of the current message.
//   cfg_we/cfg_wdata load the per-message output capacity; write only while idle.
// Path: a taken character enters the queue; its result is registered in the decode stage when popped.
// Throughput: one character per cycle while m_tready is high, set by the state update in
//   the decode stage; a four-entry queue separates classification from decoding.
// Reset: arst_n clears the message state and sets the capacity to 65535.
// Stall: while m_tready is low the result register holds, the queue fills, and
//   s_tready drops once four characters wait.
module base32_stream_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [b32d_pkg::CAP_W-1:0]  cfg_wdata,  // output_capacity
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,    // [7:0] char_code
	input  logic                        s_tlast,    // last_char
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [b32d_pkg::OUT_W-1:0]  m_tdata,    // [7:0] byte_out, [9:8] status, [25:10] byte_count
	output logic                        m_tlast,    // message_done
	output logic                        m_tuser     // byte_valid
);

	logic            push;
	logic            full;
	logic            pop;
	logic            not_empty;
	b32d_pkg::item_t push_item;
	b32d_pkg::item_t head;

	b32d_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.full     (full),
		.push     (push),
		.item     (push_item)
	);

	b32d_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	b32d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (not_empty),
		.item       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

`ifndef NO_ASSERTIONS
	a_status_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[9:8] == b32d_pkg::ST_OK)
		else $error("nonzero status without message_done");

	a_byte_means_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[9:8] == b32d_pkg::ST_OK)
		else $error("decoded byte reported together with an error");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");
`endif

endmodule
